// ===== hdl/bsc_pkg.sv =====
package bsc_pkg;

    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    localparam logic [1:0] REG_TEMP_CAL    = 2'd0;
    localparam logic [1:0] REG_PRESS_CAL_A = 2'd1;
    localparam logic [1:0] REG_PRESS_CAL_B = 2'd2;
    localparam logic [1:0] REG_PRESS_CAL_C = 2'd3;

    localparam int CAL_W   = 48;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 64;
    localparam int RAW_W   = 20;

    localparam logic [63:0] T_OFFSET   = 64'd128000;
    localparam logic [63:0] P_BASE     = 64'd1048576;
    localparam logic [63:0] P_SCALE    = 64'd3125;
    localparam logic [63:0] P_DEN_BIAS = 64'd1 << 47;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

endpackage

// ===== hdl/barometric_sensor_compensation.sv =====
// input not ready until the result is stored, so a new item is not taken before the last is done;
// the datapath uses one shared 32x32 multiplier (each 64-bit product built from partial products,
// up to 10 products per item) and a 64-step restoring divider, one quotient bit per cycle
// synchronous active-low reset clears calibration, fine temperature and all handshake state
module barometric_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // raw_sample[19:0], zero fill
    input  logic [0:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // temperature_centi[31:0], pressure_q24_8[63:32]
    output logic [1:0]  m_axis_tuser,   // kind, zero_divisor
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [bsc_pkg::APB_AW-1:0] paddr,
    input  logic [bsc_pkg::APB_DW-1:0] pwdata,
    output logic [bsc_pkg::APB_DW-1:0] prdata,
    output logic        pready
);
    import bsc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_STEP, S_MUL, S_DIV} t_state;

    t_state      r_state;
    logic [3:0]  r_step;
    logic [1:0]  r_mcnt;
    logic [5:0]  r_dcnt;
    logic        r_cmd;
    logic [RAW_W-1:0] r_adc;
    logic [CAL_W-1:0] r_tcal, r_pcal_a, r_pcal_b, r_pcal_c;
    logic [31:0] r_fine;
    logic [63:0] r_ma, r_mb, r_p, r_x, r_xx, r_y, r_den, r_q, r_rem, r_ud;
    logic        r_qneg;
    logic        r_ovalid, r_okind, r_ozero;
    logic [31:0] r_otemp, r_opress;

    logic [31:0] mx, my;
    logic [63:0] mprod;
    logic        out_free;
    logic        res_load;
    logic [31:0] t1, t_a1, t_d, t_fine, t_fine5, t_res;
    logic [63:0] xv, den_in, den, num_in, q_fix, ps, res64;
    logic [64:0] rem_sh;
    logic        rem_ge;

    always_comb begin
        case (r_mcnt)
            2'd0:    begin mx = r_ma[31:0];  my = r_mb[31:0];  end
            2'd1:    begin mx = r_ma[31:0];  my = r_mb[63:32]; end
            default: begin mx = r_ma[63:32]; my = r_mb[31:0];  end
        endcase
    end
    assign mprod = mx * my;

    assign out_free = !r_ovalid || m_axis_tready;

    // result register loads on the last step of either item kind
    assign res_load = (r_state == S_STEP) && out_free
                    && ((r_cmd == CMD_TEMP) ? (r_step == 4'd3)
                        : ((r_step == 4'd6 && den == 64'd0) || r_step == 4'd11));

    assign t1      = {16'b0, r_tcal[15:0]};
    assign t_a1    = 32'(r_adc >> 3) - {t1[30:0], 1'b0};
    assign t_d     = 32'(r_adc >> 4) - t1;
    assign t_fine  = r_x[31:0] + 32'($signed(r_p[31:0]) >>> 14);
    assign t_fine5 = {t_fine[29:0], 2'b0} + t_fine + 32'd128;
    assign t_res   = 32'($signed(t_fine5) >>> 8);

    assign xv     = {{32{r_fine[31]}}, r_fine} - T_OFFSET;
    assign den_in = r_den + (r_p << 12) + P_DEN_BIAS;
    assign den    = 64'($signed(r_p) >>> 33);
    assign num_in = ((P_BASE - 64'(r_adc)) << 31) - r_y;
    assign q_fix  = r_qneg ? (64'd0 - r_q) : r_q;
    assign ps     = 64'($signed(q_fix) >>> 13);
    assign res64  = 64'($signed(r_q + r_x + 64'($signed(r_p) >>> 19)) >>> 8)
                  + (sx16(r_pcal_c[15:0]) << 4);

    assign rem_sh = {r_rem, r_q[63]};
    assign rem_ge = rem_sh >= {1'b0, r_ud};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_mcnt   <= '0;
            r_dcnt   <= '0;
            r_tcal   <= '0;
            r_pcal_a <= '0;
            r_pcal_b <= '0;
            r_pcal_c <= '0;
            r_fine   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[4:3])
                    REG_TEMP_CAL:    r_tcal   <= pwdata[CAL_W-1:0];
                    REG_PRESS_CAL_A: r_pcal_a <= pwdata[CAL_W-1:0];
                    REG_PRESS_CAL_B: r_pcal_b <= pwdata[CAL_W-1:0];
                    REG_PRESS_CAL_C: r_pcal_c <= pwdata[CAL_W-1:0];
                    default: ;
                endcase
            end
            if (res_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tuser[0];
                        r_adc   <= s_axis_tdata[RAW_W-1:0];
                        r_step  <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_MUL: begin
                    if (r_mcnt == 2'd0) begin
                        r_p    <= mprod;
                        r_mcnt <= 2'd1;
                    end else begin
                        r_p[63:32] <= r_p[63:32] + mprod[31:0];
                        if (r_mcnt == 2'd2) begin
                            r_mcnt  <= 2'd0;
                            r_step  <= r_step + 4'd1;
                            r_state <= S_STEP;
                        end else begin
                            r_mcnt <= 2'd2;
                        end
                    end
                end
                S_DIV: begin
                    if (rem_ge) begin
                        r_rem <= 64'(rem_sh - {1'b0, r_ud});
                    end else begin
                        r_rem <= rem_sh[63:0];
                    end
                    r_q  <= {r_q[62:0], rem_ge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_step  <= r_step + 4'd1;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_mcnt <= 2'd0;
                    if (r_cmd == CMD_TEMP) begin
                        case (r_step)
                            4'd0: begin
                                r_ma <= {32'b0, t_a1};
                                r_mb <= sx16(r_tcal[31:16]);
                                r_state <= S_MUL;
                            end
                            4'd1: begin
                                r_x  <= {32'b0, 32'($signed(r_p[31:0]) >>> 11)};
                                r_ma <= {32'b0, t_d};
                                r_mb <= {32'b0, t_d};
                                r_state <= S_MUL;
                            end
                            4'd2: begin
                                r_ma <= {32'b0, 32'($signed(r_p[31:0]) >>> 12)};
                                r_mb <= sx16(r_tcal[47:32]);
                                r_state <= S_MUL;
                            end
                            default: begin
                                if (out_free) begin
                                    r_fine   <= t_fine;
                                    r_okind  <= CMD_TEMP;
                                    r_ozero  <= 1'b0;
                                    r_otemp  <= t_res;
                                    r_opress <= '0;
                                    r_state  <= S_IDLE;
                                end
                            end
                        endcase
                    end else begin
                        case (r_step)
                            4'd0: begin
                                r_x  <= xv;
                                r_ma <= xv;
                                r_mb <= xv;
                                r_state <= S_MUL;
                            end
                            4'd1: begin
                                r_xx <= r_p;
                                r_ma <= r_p;
                                r_mb <= sx16(r_pcal_b[47:32]);
                                r_state <= S_MUL;
                            end
                            4'd2: begin
                                r_y  <= r_p;
                                r_ma <= r_x;
                                r_mb <= sx16(r_pcal_b[31:16]);
                                r_state <= S_MUL;
                            end
                            4'd3: begin
                                r_y  <= r_y + (r_p << 17) + (sx16(r_pcal_b[15:0]) << 35);
                                r_ma <= r_xx;
                                r_mb <= sx16(r_pcal_a[47:32]);
                                r_state <= S_MUL;
                            end
                            4'd4: begin
                                r_den <= 64'($signed(r_p) >>> 8);
                                r_ma  <= r_x;
                                r_mb  <= sx16(r_pcal_a[31:16]);
                                r_state <= S_MUL;
                            end
                            4'd5: begin
                                r_ma <= den_in;
                                r_mb <= {48'b0, r_pcal_a[15:0]};
                                r_state <= S_MUL;
                            end
                            4'd6: begin
                                if (den == 64'd0) begin
                                    if (out_free) begin
                                        r_okind  <= CMD_PRESS;
                                        r_ozero  <= 1'b1;
                                        r_otemp  <= '0;
                                        r_opress <= '0;
                                        r_state  <= S_IDLE;
                                    end
                                end else begin
                                    r_den <= den;
                                    r_ma  <= num_in;
                                    r_mb  <= P_SCALE;
                                    r_state <= S_MUL;
                                end
                            end
                            4'd7: begin
                                r_q    <= r_p[63] ? (64'd0 - r_p) : r_p;
                                r_ud   <= r_den[63] ? (64'd0 - r_den) : r_den;
                                r_qneg <= r_p[63] ^ r_den[63];
                                r_rem  <= '0;
                                r_dcnt <= '0;
                                r_state <= S_DIV;
                            end
                            4'd8: begin
                                r_q  <= q_fix;
                                r_ma <= ps;
                                r_mb <= ps;
                                r_state <= S_MUL;
                            end
                            4'd9: begin
                                r_ma <= sx16(r_pcal_c[47:32]);
                                r_mb <= r_p;
                                r_state <= S_MUL;
                            end
                            4'd10: begin
                                r_x  <= 64'($signed(r_p) >>> 25);
                                r_ma <= sx16(r_pcal_c[31:16]);
                                r_mb <= r_q;
                                r_state <= S_MUL;
                            end
                            default: begin
                                if (out_free) begin
                                    r_okind  <= CMD_PRESS;
                                    r_ozero  <= 1'b0;
                                    r_otemp  <= '0;
                                    r_opress <= res64[31:0];
                                    r_state  <= S_IDLE;
                                end
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_TEMP_CAL:    prdata = {16'b0, r_tcal};
            REG_PRESS_CAL_A: prdata = {16'b0, r_pcal_a};
            REG_PRESS_CAL_B: prdata = {16'b0, r_pcal_b};
            REG_PRESS_CAL_C: prdata = {16'b0, r_pcal_c};
            default:         prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_opress, r_otemp};
    assign m_axis_tuser  = {r_ozero, r_okind};

`ifndef SYNTHESIS
    a_mul_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_mcnt != 2'd3))
        else $error("multiplier phase out of range");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted a transfer while busy");
    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_ud != 64'd0))
        else $error("divider started with zero divisor");
    a_temp_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_okind == CMD_TEMP) |-> (!r_ozero && r_opress == 32'd0))
        else $error("temperature result carries pressure fields");
`endif

endmodule
